@@ rtl/code128_symbol_decoder_top_macros.svh @@
// Assertion macros for the Code 128 symbol decoder.
`ifndef CODE128_SYMBOL_DECODER_TOP_MACROS_SVH
`define CODE128_SYMBOL_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define C128_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define C128_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/c128_pkg.sv @@
// Shared types, symbol codes and helper functions of the Code 128 decoder.
package c128_pkg;

	localparam logic [6:0] SYM_SHIFT   = 7'd98;
	localparam logic [6:0] SYM_TO_C    = 7'd99;
	localparam logic [6:0] SYM_TO_B    = 7'd100;
	localparam logic [6:0] SYM_TO_A    = 7'd101;
	localparam logic [6:0] SYM_START_A = 7'd103;
	localparam logic [6:0] SYM_START_C = 7'd105;
	localparam logic [6:0] SYM_STOP    = 7'd106;
	localparam logic [6:0] CHECK_MOD   = 7'd103;

	localparam logic [6:0] SYM_A_CTRL  = 7'd64;
	localparam logic [6:0] SYM_AB_END  = 7'd96;
	localparam logic [6:0] SYM_C_END   = 7'd100;

	localparam logic [6:0] CHAR_SPACE  = 7'd32;
	localparam logic [6:0] CHAR_ZERO   = 7'd48;

	localparam logic [2:0] KIND_CHAR     = 3'd0;
	localparam logic [2:0] KIND_OK       = 3'd1;
	localparam logic [2:0] KIND_CHECKSUM = 3'd2;
	localparam logic [2:0] KIND_FORMAT   = 3'd3;
	localparam logic [2:0] KIND_EMPTY    = 3'd4;

	typedef enum logic [1:0] {
		SET_A = 2'd0,
		SET_B = 2'd1,
		SET_C = 2'd2
	} set_t;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_DATA   = 2'd1,
		OP_STOP   = 2'd2,
		OP_FORMAT = 2'd3
	} op_t;

	// One classified symbol handed from front to back.
	typedef struct packed {
		op_t        op;
		logic [6:0] sym;
		logic [6:0] term;
		logic [1:0] count;
		logic [6:0] char0;
		logic [6:0] char1;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [6:0] char_code;
		logic       row_end;
	} res_t;

	// x mod 103 for a 14-bit x: fold three times with 128 = 25 (mod 103), then one trim by 206 or 103.
	function automatic logic [6:0] mod103(input logic [13:0] x);
		logic [11:0] f1;
		logic [9:0]  f2;
		logic [7:0]  f3;
		logic [7:0]  r;
		f1 = {1'b0, x[13:7], 4'b0} + {2'b0, x[13:7], 3'b0} + {5'b0, x[13:7]}
			+ {5'b0, x[6:0]};
		f2 = {1'b0, f1[11:7], 4'b0} + {2'b0, f1[11:7], 3'b0} + {5'b0, f1[11:7]}
			+ {3'b0, f1[6:0]};
		f3 = {1'b0, f2[9:7], 4'b0} + {2'b0, f2[9:7], 3'b0} + {5'b0, f2[9:7]}
			+ {1'b0, f2[6:0]};
		if (f3 >= {CHECK_MOD, 1'b0}) begin
			r = f3 - {CHECK_MOD, 1'b0};
		end else if (f3 >= {1'b0, CHECK_MOD}) begin
			r = f3 - {1'b0, CHECK_MOD};
		end else begin
			r = f3;
		end
		return r[6:0];
	endfunction

	// Tens digit of a value below 100.
	function automatic logic [3:0] tens_digit(input logic [6:0] v);
		logic [3:0] t;
		t = 4'd0;
		for (int i = 1; i < 10; i++) begin
			if (v >= 7'(10 * i)) begin
				t = t + 4'd1;
			end
		end
		return t;
	endfunction

endpackage

@@ rtl/code128_symbol_decoder_top.sv @@
// Top level of the Code 128 symbol-value decoder.
// Accepts one symbol value per cycle through push/full while full is low, and
// delivers characters and row status through empty/pop. A symbol is classified
// in the front part (code set, shift, position, weighted term), held in its
// stage register and enters the command queue when the queue has room. The
// results it causes (the characters held from the previous symbol, or the row
// status) go into the result queue, whose head drives the result ports. The
// back part writes one result per cycle into a two-entry result queue while
// that queue has room. The symbol after a code set C digit pair releases both
// digits, so it stays in the back part until both are written. The sustained
// rate is one symbol per cycle for symbols releasing at most one character,
// while results are popped. There is no clearing pass after reset.
`include "code128_symbol_decoder_top_macros.svh"

module code128_symbol_decoder_top #(
	parameter int CMD_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [6:0] symbol_value,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] kind,
	output logic [6:0] char_code,
	output logic       row_end
);
	import c128_pkg::*;

	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;
	cmd_t cmd_wr;
	cmd_t cmd_rd;

	c128_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.symbol_value (symbol_value),
		.cmd_push     (cmd_push),
		.cmd          (cmd_wr),
		.cmd_full     (cmd_full)
	);

	c128_cmd_queue #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_wr),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_rd),
		.empty   (cmd_empty)
	);

	c128_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_rd),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.char_code (char_code),
		.row_end   (row_end)
	);

	`C128_ASSERT_IMP(a_end_matches_kind, clk, arst_n, !empty, row_end == (kind != KIND_CHAR), "row_end disagrees with item kind")
	`C128_ASSERT_IMP(a_status_no_char, clk, arst_n, !empty && row_end, char_code == 7'd0, "status item carries a character")
	`C128_ASSERT_IMP(a_cmd_no_overflow, clk, arst_n, cmd_push, !cmd_full, "command pushed into full queue")
	`C128_ASSERT_NXT(a_cmd_kept, clk, arst_n, cmd_push && !cmd_pop, !cmd_empty, "pushed command lost")

endmodule

@@ rtl/c128_front.sv @@
// Front part: accepts symbols, tracks row, code set and position, builds commands.
module c128_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [6:0]      symbol_value,
	output logic            cmd_push,
	output c128_pkg::cmd_t  cmd,
	input  logic            cmd_full
);
	import c128_pkg::*;

	logic        row_active_q;
	set_t        code_set_q;
	logic        shift_q;
	logic [6:0]  position_q;

	logic        valid_s1;
	op_t         op_s1;
	logic [6:0]  sym_s1;
	set_t        set_s1;
	logic [13:0] prod_s1;

	logic        accept;
	logic        row_n;
	set_t        set_n;
	logic        shift_n;
	logic [6:0]  pos_n;
	logic [6:0]  pos_inc;
	logic [6:0]  start_off;
	logic        is_start;
	op_t         op_d;
	logic [3:0]  tens;
	logic [6:0]  ones;

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;

	assign pos_inc   = (position_q == CHECK_MOD - 7'd1) ? 7'd0 : position_q + 7'd1;
	assign start_off = symbol_value - SYM_START_A;
	assign is_start  = symbol_value inside {[SYM_START_A:SYM_START_C]};

	always_comb begin
		row_n   = row_active_q;
		set_n   = code_set_q;
		shift_n = shift_q;
		pos_n   = position_q;
		op_d    = OP_FORMAT;
		if (!row_active_q) begin
			if (is_start) begin
				row_n   = 1'b1;
				set_n   = set_t'(start_off[1:0]);
				shift_n = 1'b0;
				pos_n   = 7'd0;
				op_d    = OP_START;
			end
		end else if (symbol_value == SYM_STOP || symbol_value >= SYM_START_A) begin
			op_d    = (symbol_value == SYM_STOP) ? OP_STOP : OP_FORMAT;
			row_n   = 1'b0;
			set_n   = SET_A;
			shift_n = 1'b0;
			pos_n   = 7'd0;
		end else begin
			op_d    = OP_DATA;
			pos_n   = pos_inc;
			shift_n = 1'b0;
			case (code_set_q)
				SET_C: begin
					if (symbol_value == SYM_TO_A) begin
						set_n = SET_A;
					end else if (symbol_value == SYM_TO_B) begin
						set_n = SET_B;
					end
				end
				SET_B: begin
					if (symbol_value == SYM_SHIFT) begin
						shift_n = 1'b1;
						set_n   = SET_A;
					end else if (symbol_value == SYM_TO_A) begin
						set_n = SET_A;
					end else if (symbol_value == SYM_TO_C) begin
						set_n = SET_C;
					end
				end
				default: begin
					if (symbol_value == SYM_SHIFT) begin
						shift_n = 1'b1;
						set_n   = SET_B;
					end else if (symbol_value == SYM_TO_B) begin
						set_n = SET_B;
					end else if (symbol_value == SYM_TO_C) begin
						set_n = SET_C;
					end
				end
			endcase
			if (shift_q) begin
				set_n = (set_n == SET_A) ? SET_B : SET_A;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_active_q <= 1'b0;
			code_set_q   <= SET_A;
			shift_q      <= 1'b0;
			position_q   <= 7'd0;
			valid_s1     <= 1'b0;
		end else begin
			if (accept) begin
				row_active_q <= row_n;
				code_set_q   <= set_n;
				shift_q      <= shift_n;
				position_q   <= pos_n;
				valid_s1     <= 1'b1;
			end else if (cmd_push) begin
				valid_s1     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_d;
			sym_s1  <= symbol_value;
			set_s1  <= code_set_q;
			prod_s1 <= {7'b0, pos_inc} * {7'b0, symbol_value};
		end
	end

	assign tens = tens_digit(sym_s1);
	assign ones = sym_s1 - ({tens, 3'b0} + {2'b0, tens, 1'b0});

	always_comb begin
		cmd.op    = op_s1;
		cmd.sym   = sym_s1;
		cmd.term  = mod103(prod_s1);
		cmd.count = 2'd0;
		cmd.char0 = 7'd0;
		cmd.char1 = 7'd0;
		case (set_s1)
			SET_C: begin
				if (sym_s1 < SYM_C_END) begin
					cmd.count = 2'd2;
					cmd.char0 = CHAR_ZERO + {3'b0, tens};
					cmd.char1 = CHAR_ZERO + ones;
				end
			end
			SET_B: begin
				if (sym_s1 < SYM_AB_END) begin
					cmd.count = 2'd1;
					cmd.char0 = CHAR_SPACE + sym_s1;
				end
			end
			default: begin
				if (sym_s1 < SYM_A_CTRL) begin
					cmd.count = 2'd1;
					cmd.char0 = CHAR_SPACE + sym_s1;
				end else if (sym_s1 < SYM_AB_END) begin
					cmd.count = 2'd1;
					cmd.char0 = sym_s1 - SYM_A_CTRL;
				end
			end
		endcase
	end

endmodule

@@ rtl/c128_cmd_queue.sv @@
// Command queue between the front and back parts.
module c128_cmd_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  c128_pkg::cmd_t  wr_data,
	output logic            full,
	input  logic            pop,
	output c128_pkg::cmd_t  rd_data,
	output logic            empty
);
	import c128_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ rtl/c128_back.sv @@
// Back part: held characters, checksum, row status and the result queue.
module c128_back (
	input  logic            clk,
	input  logic            arst_n,
	input  c128_pkg::cmd_t  cmd,
	input  logic            cmd_valid,
	output logic            cmd_pop,
	output logic            empty,
	input  logic            pop,
	output logic [2:0]      kind,
	output logic [6:0]      char_code,
	output logic            row_end
);
	import c128_pkg::*;

	localparam logic [1:0] RES_FULL = 2'd2;

	logic [6:0] pend0_q;
	logic [6:0] pend1_q;
	logic [1:0] pcount_q;
	logic [6:0] chk_q;
	logic [6:0] last_q;
	logic [6:0] prev_q;
	logic       any_q;
	logic       idx_q;

	res_t       res_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] rcount_q;

	logic       res_pop;
	logic       room;
	logic       res_push;
	res_t       res;
	logic [6:0] diff;
	logic [7:0] sum;
	logic [6:0] chk_next;

	assign empty   = (rcount_q == 2'd0);
	assign res_pop = pop && !empty;
	assign room    = (rcount_q != RES_FULL) || res_pop;

	assign diff     = (chk_q >= last_q) ? chk_q - last_q : chk_q + CHECK_MOD - last_q;
	assign sum      = {1'b0, chk_q} + {1'b0, cmd.term};
	assign chk_next = (sum >= {1'b0, CHECK_MOD}) ? 7'(sum - {1'b0, CHECK_MOD}) : sum[6:0];

	always_comb begin
		res_push      = 1'b0;
		cmd_pop       = 1'b0;
		res.kind      = KIND_CHAR;
		res.char_code = 7'd0;
		res.row_end   = 1'b0;
		if (cmd_valid) begin
			case (cmd.op)
				OP_DATA: begin
					if (pcount_q == 2'd0) begin
						cmd_pop = 1'b1;
					end else begin
						res_push      = room;
						res.char_code = idx_q ? pend1_q : pend0_q;
						cmd_pop       = room && ({1'b0, idx_q} + 2'd1 == pcount_q);
					end
				end
				OP_STOP: begin
					res_push    = room;
					cmd_pop     = room;
					res.row_end = 1'b1;
					if (diff != prev_q) begin
						res.kind = KIND_CHECKSUM;
					end else begin
						res.kind = any_q ? KIND_OK : KIND_EMPTY;
					end
				end
				OP_FORMAT: begin
					res_push    = room;
					cmd_pop     = room;
					res.row_end = 1'b1;
					res.kind    = KIND_FORMAT;
				end
				default: begin
					cmd_pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend0_q  <= 7'd0;
			pend1_q  <= 7'd0;
			pcount_q <= 2'd0;
			chk_q    <= 7'd0;
			last_q   <= 7'd0;
			prev_q   <= 7'd0;
			any_q    <= 1'b0;
			idx_q    <= 1'b0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			rcount_q <= 2'd0;
		end else begin
			if (cmd_pop) begin
				idx_q <= 1'b0;
				if (cmd.op == OP_DATA) begin
					pend0_q  <= cmd.char0;
					pend1_q  <= cmd.char1;
					pcount_q <= cmd.count;
					chk_q    <= chk_next;
					last_q   <= cmd.term;
					prev_q   <= cmd.sym;
					any_q    <= any_q || (cmd.count != 2'd0);
				end else begin
					pcount_q <= 2'd0;
					last_q   <= 7'd0;
					prev_q   <= 7'd0;
					any_q    <= 1'b0;
					chk_q    <= (cmd.op == OP_START) ? cmd.sym - SYM_START_A : 7'd0;
				end
			end else if (res_push) begin
				idx_q <= 1'b1;
			end
			if (res_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (res_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (res_push && !res_pop) begin
				rcount_q <= rcount_q + 2'd1;
			end else if (res_pop && !res_push) begin
				rcount_q <= rcount_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_mem_q[wr_ptr_q] <= res;
		end
	end

	assign kind      = res_mem_q[rd_ptr_q].kind;
	assign char_code = res_mem_q[rd_ptr_q].char_code;
	assign row_end   = res_mem_q[rd_ptr_q].row_end;

endmodule
